FILE: rtl/nearest_neighbor_image_scaler_top_assert.svh
// Assertion macros shared by the scaler modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_TOP_ASSERT_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_TOP_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define NNIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// A condition in one cycle that must be followed by a consequence in the next.
`define NNIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/nnis_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nnis_pkg;

  // Frame store geometry.
  localparam int MaxWidth   = 256;
  localparam int MaxHeight  = 256;
  localparam int StoreDepth = MaxWidth * MaxHeight;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int CoordW     = $clog2(MaxWidth > MaxHeight ? MaxWidth : MaxHeight);

  // Field and register widths.
  localparam int DimW  = 9;
  localparam int ZoomW = 10;
  localparam int PixW  = 24;
  localparam int OutW  = 12;
  localparam int AreaW = 2 * DimW;

  // Output size arithmetic.
  localparam int Percent     = 100;
  localparam int Align       = 4;
  localparam int OutDimLimit = 4092;
  localparam int ProdW       = DimW + ZoomW;
  // floor(x / 100) is taken as (x * RcpMul) >> RcpShift, exact for x below 493448,
  // which covers every source size times zoom.
  localparam int RcpShift    = 25;
  localparam int RcpMul      = (2 ** RcpShift + Percent - 1) / Percent;
  localparam int RcpW        = 19;
  localparam int DimQW       = ProdW + RcpW - RcpShift;

  // Divider: dividend is an output coordinate times 100, two quotient bits a cycle.
  localparam int DivW      = 20;
  localparam int DivCycles = DivW / 2;
  localparam int DivCntW   = $clog2(DivCycles + 1);

  // Request codes.
  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqFetch = 1'b1;

  // Register indexes on the configuration port, one word apart.
  localparam logic [1:0] RegSrcWidth  = 2'd0;
  localparam logic [1:0] RegSrcHeight = 2'd1;
  localparam logic [1:0] RegZoom      = 2'd2;

  typedef struct packed {
    logic load;
    logic dim_mul;
    logic dim_rcp;
    logic dim_fin;
    logic chk;
    logic take_x;
    logic take_y;
    logic addr;
    logic read;
    logic emit;
  } nnis_cmd_t;

  typedef struct packed {
    logic empty;
    logic div_done;
  } nnis_sts_t;

endpackage

`default_nettype wire

FILE: rtl/nnis_div.sv
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_neighbor_image_scaler_top_assert.svh"

module nnis_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        go_i,
  input  wire logic [nnis_pkg::DivW-1:0]   dividend_i,
  input  wire logic [nnis_pkg::ZoomW-1:0]  divisor_i,
  output logic      [nnis_pkg::DivW-1:0]   quot_o,
  output logic                             done_o
);

  localparam int DivW    = nnis_pkg::DivW;
  localparam int ZoomW   = nnis_pkg::ZoomW;
  localparam int DivCntW = nnis_pkg::DivCntW;

  logic [DivCntW-1:0]       cnt_q, cnt_d;
  logic [ZoomW-1:0]         rem_q;
  logic [DivW-1:0]          quo_q;
  logic [DivW+ZoomW-1:0]    step1_c, step2_c;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  function automatic logic [DivW+ZoomW-1:0] div_step(
    input logic [ZoomW-1:0] rem,
    input logic [DivW-1:0]  quo,
    input logic [ZoomW-1:0] dvs
  );
    logic [ZoomW:0] t;
    logic           fits;
    t    = {rem, quo[DivW-1]};
    fits = (t >= {1'b0, dvs});
    if (fits) begin
      t = t - {1'b0, dvs};
    end
    return {t[ZoomW-1:0], quo[DivW-2:0], fits};
  endfunction

  assign step1_c = div_step(rem_q, quo_q, divisor_i);
  assign step2_c = div_step(step1_c[DivW+ZoomW-1:DivW], step1_c[DivW-1:0], divisor_i);

  always_comb begin
    cnt_d = cnt_q;
    if (go_i) begin
      cnt_d = DivCntW'(nnis_pkg::DivCycles);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (cnt_q != '0) begin
      rem_q <= step2_c[DivW+ZoomW-1:DivW];
      quo_q <= step2_c[DivW-1:0];
    end
  end

  assign quot_o = quo_q;
  assign done_o = (cnt_q == '0);

  `NNIS_ASSERT(a_div_go_when_idle, !(go_i && !done_o), "divider started while running")

endmodule

`default_nettype wire

FILE: rtl/nnis_dp.sv
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_neighbor_image_scaler_top_assert.svh"

module nnis_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire nnis_pkg::nnis_cmd_t           cmd_i,
  output nnis_pkg::nnis_sts_t                sts_o,
  input  wire logic [nnis_pkg::PixW-1:0]     pixel_in_i,
  input  wire logic [nnis_pkg::DimW-1:0]     source_width_i,
  input  wire logic [nnis_pkg::DimW-1:0]     source_height_i,
  input  wire logic [nnis_pkg::ZoomW-1:0]    zoom_percent_i,
  output logic      [nnis_pkg::PixW-1:0]     pixel_out_o,
  output logic      [nnis_pkg::OutW-1:0]     out_x_o,
  output logic      [nnis_pkg::OutW-1:0]     out_y_o,
  output logic                               end_of_frame_o,
  output logic      [nnis_pkg::OutW-1:0]     output_width_o,
  output logic      [nnis_pkg::OutW-1:0]     output_height_o
);

  localparam int DimW   = nnis_pkg::DimW;
  localparam int PixW   = nnis_pkg::PixW;
  localparam int OutW   = nnis_pkg::OutW;
  localparam int AreaW  = nnis_pkg::AreaW;
  localparam int AddrW  = nnis_pkg::AddrW;
  localparam int CoordW = nnis_pkg::CoordW;
  localparam int ProdW  = nnis_pkg::ProdW;
  localparam int FullW  = nnis_pkg::ProdW + nnis_pkg::RcpW;
  localparam int DimQW  = nnis_pkg::DimQW;
  localparam int DivW   = nnis_pkg::DivW;

  // Effective source size, saturated to the frame store.
  logic [DimW-1:0]   w_c, h_c;
  logic [AreaW-1:0]  area_c;

  assign w_c = (source_width_i > DimW'(nnis_pkg::MaxWidth)) ?
               DimW'(nnis_pkg::MaxWidth) : source_width_i;
  assign h_c = (source_height_i > DimW'(nnis_pkg::MaxHeight)) ?
               DimW'(nnis_pkg::MaxHeight) : source_height_i;
  assign area_c = AreaW'(w_c) * AreaW'(h_c);

  // ---------------------------------------------------------------- loads
  logic [AddrW-1:0]  load_q, load_d, base_c;
  logic [AreaW-1:0]  inc_c;
  logic              wr_c;

  // An address left outside the source area by a size change restarts at zero.
  assign base_c = (AreaW'(load_q) >= area_c) ? '0 : load_q;
  assign inc_c  = AreaW'(base_c) + 1'b1;
  assign wr_c   = cmd_i.load && (area_c != '0);
  assign load_d = (inc_c >= area_c) ? '0 : inc_c[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
    end else if (wr_c) begin
      load_q <= load_d;
    end
  end

  // ------------------------------------------------------- output size
  logic [ProdW-1:0]  wprod_q, hprod_q;
  logic [FullW-1:0]  wfull_c, hfull_c;
  logic [DimQW-1:0]  wdim_q, hdim_q;
  logic [OutW-1:0]   ow_q, oh_q;
  logic              empty_c, div_done_c;

  function automatic logic [OutW-1:0] align_dim(input logic [DimQW-1:0] d);
    logic [DimQW-1:0] a;
    a = (d + DimQW'(nnis_pkg::Align - 1)) & ~DimQW'(nnis_pkg::Align - 1);
    if (a > DimQW'(nnis_pkg::OutDimLimit)) begin
      return OutW'(nnis_pkg::OutDimLimit);
    end
    return a[OutW-1:0];
  endfunction

  assign wfull_c = FullW'(wprod_q) * FullW'(nnis_pkg::RcpMul);
  assign hfull_c = FullW'(hprod_q) * FullW'(nnis_pkg::RcpMul);

  always_ff @(posedge clk_i) begin
    if (cmd_i.dim_mul) begin
      wprod_q <= ProdW'(w_c) * ProdW'(zoom_percent_i);
      hprod_q <= ProdW'(h_c) * ProdW'(zoom_percent_i);
    end
    if (cmd_i.dim_rcp) begin
      wdim_q <= wfull_c[nnis_pkg::RcpShift +: DimQW];
      hdim_q <= hfull_c[nnis_pkg::RcpShift +: DimQW];
    end
    if (cmd_i.dim_fin) begin
      ow_q <= align_dim(wdim_q);
      oh_q <= align_dim(hdim_q);
    end
  end

  // A zero source or zero zoom always ends in a zero output dimension.
  assign empty_c = (ow_q == '0) || (oh_q == '0);
  assign sts_o   = {empty_c, div_done_c};

  // ------------------------------------------------------------ counters
  logic [OutW-1:0]   col_q, col_d, row_q, row_d, col_eff_c, row_eff_c;
  logic              out_range_c, col_last_c, row_last_c;

  assign out_range_c = (col_q >= ow_q) || (row_q >= oh_q);
  assign col_eff_c   = out_range_c ? '0 : col_q;
  assign row_eff_c   = out_range_c ? '0 : row_q;
  assign col_last_c  = ((OutW+1)'(col_q) + 1'b1) >= (OutW+1)'(ow_q);
  assign row_last_c  = ((OutW+1)'(row_q) + 1'b1) >= (OutW+1)'(oh_q);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.chk) begin
      col_d = col_eff_c;
      row_d = row_eff_c;
    end else if (cmd_i.emit) begin
      if (col_last_c) begin
        col_d = '0;
        row_d = row_last_c ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ----------------------------------------------- source coordinates
  logic [DivW-1:0]   dividend_c, quot_c;
  logic              div_go_c;
  logic [CoordW-1:0] sx_q, sy_q;

  function automatic logic [CoordW-1:0] clamp_coord(
    input logic [DivW-1:0] q,
    input logic [DimW-1:0] src
  );
    logic [DimW-1:0] last;
    last = src - 1'b1;
    if (q >= DivW'(src)) begin
      return last[CoordW-1:0];
    end
    return q[CoordW-1:0];
  endfunction

  // The column is divided right after the range check, the row right after.
  assign div_go_c   = cmd_i.chk || cmd_i.take_x;
  assign dividend_c = cmd_i.chk ? DivW'(col_eff_c) * DivW'(nnis_pkg::Percent)
                                : DivW'(row_q) * DivW'(nnis_pkg::Percent);

  nnis_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (div_go_c),
    .dividend_i (dividend_c),
    .divisor_i  (zoom_percent_i),
    .quot_o     (quot_c),
    .done_o     (div_done_c)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_x) begin
      sx_q <= clamp_coord(quot_c, w_c);
    end
    if (cmd_i.take_y) begin
      sy_q <= clamp_coord(quot_c, h_c);
    end
  end

  // --------------------------------------------------------- frame store
  logic [AreaW-1:0]  addr_c;
  logic [AddrW-1:0]  addr_q;
  logic [PixW-1:0]   pix_q;
  logic [PixW-1:0]   frame_q [nnis_pkg::StoreDepth];

  assign addr_c = AreaW'(sy_q) * AreaW'(w_c) + AreaW'(sx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr) begin
      addr_q <= addr_c[AddrW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_c) begin
      frame_q[base_c] <= pixel_in_i;
    end
    if (cmd_i.read) begin
      pix_q <= frame_q[addr_q];
    end
  end

  // -------------------------------------------------------------- result
  assign pixel_out_o     = pix_q;
  assign out_x_o         = col_q;
  assign out_y_o         = row_q;
  assign output_width_o  = ow_q;
  assign output_height_o = oh_q;
  assign end_of_frame_o  = (((OutW+1)'(col_q) + 1'b1) == (OutW+1)'(ow_q)) &&
                           (((OutW+1)'(row_q) + 1'b1) == (OutW+1)'(oh_q));

  `NNIS_ASSERT_NEXT(a_chk_in_range, cmd_i.chk, !out_range_c, "counters outside the output")
  `NNIS_ASSERT_NEXT(a_eof_wrap, cmd_i.emit && end_of_frame_o, {col_q, row_q} == '0, "wrap missed")
  `NNIS_ASSERT_NEXT(a_load_bound, wr_c, AreaW'(load_q) < $past(area_c), "load address past area")

endmodule

`default_nettype wire

FILE: rtl/nnis_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_neighbor_image_scaler_top_assert.svh"

module nnis_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic                  req_type_i,
  input  wire nnis_pkg::nnis_sts_t   sts_i,
  output nnis_pkg::nnis_cmd_t        cmd_o,
  output logic                       busy_o,
  output logic                       out_valid_o
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StDim1 = 4'd1;
  localparam logic [3:0] StDim2 = 4'd2;
  localparam logic [3:0] StDim3 = 4'd3;
  localparam logic [3:0] StChk  = 4'd4;
  localparam logic [3:0] StDivX = 4'd5;
  localparam logic [3:0] StDivY = 4'd6;
  localparam logic [3:0] StAddr = 4'd7;
  localparam logic [3:0] StRead = 4'd8;
  localparam logic [3:0] StEmit = 4'd9;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        // Loads finish in the cycle they are taken; fetches run the sequence.
        if (start_i) begin
          if (req_type_i == nnis_pkg::ReqFetch) begin
            state_d = StDim1;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      StDim1: begin
        cmd_o.dim_mul = 1'b1;
        state_d       = StDim2;
      end
      StDim2: begin
        cmd_o.dim_rcp = 1'b1;
        state_d       = StDim3;
      end
      StDim3: begin
        cmd_o.dim_fin = 1'b1;
        state_d       = StChk;
      end
      StChk: begin
        if (sts_i.empty) begin
          state_d = StIdle;
        end else begin
          cmd_o.chk = 1'b1;
          state_d   = StDivX;
        end
      end
      StDivX: begin
        if (sts_i.div_done) begin
          cmd_o.take_x = 1'b1;
          state_d      = StDivY;
        end
      end
      StDivY: begin
        if (sts_i.div_done) begin
          cmd_o.take_y = 1'b1;
          state_d      = StAddr;
        end
      end
      StAddr: begin
        cmd_o.addr = 1'b1;
        state_d    = StRead;
      end
      StRead: begin
        cmd_o.read = 1'b1;
        state_d    = StEmit;
      end
      StEmit: begin
        cmd_o.emit = 1'b1;
        state_d    = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o      = (state_q != StIdle);
  assign out_valid_o = (state_q == StEmit);

  `NNIS_ASSERT_NEXT(a_fetch_busy, start_i && !busy_o && (req_type_i == nnis_pkg::ReqFetch), busy_o, "fetch request did not start the sequence")
  `NNIS_ASSERT_NEXT(a_strobe_ends, out_valid_o, !busy_o && !out_valid_o, "result strobe not followed by idle")

endmodule

`default_nettype wire

FILE: rtl/nearest_neighbor_image_scaler_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Nearest-neighbor image scaler. A request is taken when start is high and busy
// is low. A load request (req_type_i low) writes pixel_in_i to the next place
// of the 64K x 24 frame store in raster order and completes in its own cycle,
// so loads can follow each other every cycle with busy staying low. A fetch
// request produces the next output pixel in raster order: busy stays high
// through the whole sequence, whose length is set mostly by the two divisions
// (column and row, each times 100 over zoom) on the one shared divider that
// retires two quotient bits per cycle. The result appears in the last busy
// cycle, marked by out_valid_o for exactly that cycle; the receiver cannot
// stall it and must take it then. When the output frame is empty a fetch ends
// after the size steps and the empty check, with no result. The frame store
// has no reset and needs no clearing pass; read only what was loaded. Registers
// may be written over the APB port only while the block is idle.
module nearest_neighbor_image_scaler_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          req_type_i,
  input  wire logic [nnis_pkg::PixW-1:0]     pixel_in_i,
  output logic                               out_valid_o,
  output logic      [nnis_pkg::PixW-1:0]     pixel_out_o,
  output logic      [nnis_pkg::OutW-1:0]     out_x_o,
  output logic      [nnis_pkg::OutW-1:0]     out_y_o,
  output logic                               end_of_frame_o,
  output logic      [nnis_pkg::OutW-1:0]     output_width_o,
  output logic      [nnis_pkg::OutW-1:0]     output_height_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [3:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);

  localparam int DimW  = nnis_pkg::DimW;
  localparam int ZoomW = nnis_pkg::ZoomW;

  logic [DimW-1:0]   src_w_q, src_h_q;
  logic [ZoomW-1:0]  zoom_q;
  logic              wr_en_c;

  assign pready  = 1'b1;
  assign wr_en_c = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= DimW'(256);
      src_h_q <= DimW'(256);
      zoom_q  <= ZoomW'(nnis_pkg::Percent);
    end else if (wr_en_c) begin
      case (paddr[3:2])
        nnis_pkg::RegSrcWidth:  src_w_q <= pwdata[DimW-1:0];
        nnis_pkg::RegSrcHeight: src_h_q <= pwdata[DimW-1:0];
        nnis_pkg::RegZoom:      zoom_q  <= pwdata[ZoomW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      nnis_pkg::RegSrcWidth:  prdata = {{(32-DimW){1'b0}}, src_w_q};
      nnis_pkg::RegSrcHeight: prdata = {{(32-DimW){1'b0}}, src_h_q};
      nnis_pkg::RegZoom:      prdata = {{(32-ZoomW){1'b0}}, zoom_q};
      default:                prdata = '0;
    endcase
  end

  nnis_pkg::nnis_cmd_t cmd;
  nnis_pkg::nnis_sts_t sts;

  nnis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_type_i  (req_type_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy),
    .out_valid_o (out_valid_o)
  );

  nnis_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .pixel_in_i      (pixel_in_i),
    .source_width_i  (src_w_q),
    .source_height_i (src_h_q),
    .zoom_percent_i  (zoom_q),
    .pixel_out_o     (pixel_out_o),
    .out_x_o         (out_x_o),
    .out_y_o         (out_y_o),
    .end_of_frame_o  (end_of_frame_o),
    .output_width_o  (output_width_o),
    .output_height_o (output_height_o)
  );

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int ClkHalf       = 4;
  localparam int ResetCycles   = 9;
  localparam int SettleCycles  = 40;
  localparam int WatchdogLimit = 3000;
  localparam int IdlePercent   = 37;
  localparam int RandomItems   = 1400;

  localparam int PixW        = nnis_pkg::PixW;
  localparam int OutW        = nnis_pkg::OutW;
  localparam int StoreDepth  = nnis_pkg::StoreDepth;
  localparam int MaxWidth    = nnis_pkg::MaxWidth;
  localparam int MaxHeight   = nnis_pkg::MaxHeight;
  localparam int Percent     = nnis_pkg::Percent;
  localparam int Align       = nnis_pkg::Align;
  localparam int OutDimLimit = nnis_pkg::OutDimLimit;

  typedef struct {
    logic [PixW-1:0] pixel;
    logic [OutW-1:0] x;
    logic [OutW-1:0] y;
    logic            eof;
    logic [OutW-1:0] width;
    logic [OutW-1:0] height;
  } scaled_pixel_t;

  typedef struct {
    bit            produces;
    int unsigned   addr;
    scaled_pixel_t px;
  } fetch_preview_t;

  class scaler_scoreboard;
    logic [PixW-1:0] frame_mem [StoreDepth];
    bit              loaded    [StoreDepth];
    int unsigned     load_ptr, col, row;
    int unsigned     src_w, src_h, zoom;
    scaled_pixel_t   pending[$];
    int unsigned     errors, n_loads, n_fetches, n_checked, n_settings;

    function new();
      load_ptr = 0;
      col      = 0;
      row      = 0;
      src_w    = 256;
      src_h    = 256;
      zoom     = 100;
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned limit);
      return v > limit ? limit : v;
    endfunction

    function int unsigned scaled_size(int unsigned src);
      int unsigned d;
      d = (src * zoom) / Percent;
      d = (d + Align - 1) / Align * Align;
      return d > OutDimLimit ? OutDimLimit : d;
    endfunction

    function int unsigned source_coord(int unsigned o, int unsigned src);
      int unsigned s;
      s = (o * Percent) / zoom;
      return s >= src ? src - 1 : s;
    endfunction

    function void set_register(int idx, int unsigned value);
      n_settings++;
      case (idx)
        nnis_pkg::RegSrcWidth:  src_w = value & 'h1FF;
        nnis_pkg::RegSrcHeight: src_h = value & 'h1FF;
        nnis_pkg::RegZoom:      zoom  = value & 'h3FF;
        default: ;
      endcase
    endfunction

    // Works out what the next fetch would return without touching the counters.
    function fetch_preview_t preview_fetch();
      fetch_preview_t p;
      int unsigned w, h, ow, oh, c, r, sx, sy;
      p.produces = 0;
      p.addr     = 0;
      w = clamp_dim(src_w, MaxWidth);
      h = clamp_dim(src_h, MaxHeight);
      if (w * h == 0 || zoom == 0) return p;
      ow = scaled_size(w);
      oh = scaled_size(h);
      if (ow == 0 || oh == 0) return p;
      c = col;
      r = row;
      if (c >= ow || r >= oh) begin
        c = 0;
        r = 0;
      end
      sx = source_coord(c, w);
      sy = source_coord(r, h);
      p.produces  = 1;
      p.addr      = (sy * w + sx) % StoreDepth;
      p.px.pixel  = frame_mem[p.addr];
      p.px.x      = c[OutW-1:0];
      p.px.y      = r[OutW-1:0];
      p.px.eof    = (c + 1 == ow) && (r + 1 == oh);
      p.px.width  = ow[OutW-1:0];
      p.px.height = oh[OutW-1:0];
      return p;
    endfunction

    // A fetch may only be sent when it reads a pixel that was loaded.
    function bit fetch_is_safe();
      fetch_preview_t p;
      p = preview_fetch();
      return !p.produces || loaded[p.addr];
    endfunction

    function void note_request(logic req, logic [PixW-1:0] pix);
      fetch_preview_t p;
      int unsigned    area, ow, oh;
      if (req == nnis_pkg::ReqLoad) begin
        n_loads++;
        area = clamp_dim(src_w, MaxWidth) * clamp_dim(src_h, MaxHeight);
        if (area == 0) return;
        if (load_ptr >= area) load_ptr = 0;
        frame_mem[load_ptr] = pix;
        loaded[load_ptr]    = 1;
        load_ptr = (load_ptr + 1 >= area) ? 0 : load_ptr + 1;
      end else begin
        n_fetches++;
        p = preview_fetch();
        if (!p.produces) return;
        pending.push_back(p.px);
        ow = p.px.width;
        oh = p.px.height;
        if (p.px.x + 1 >= ow) begin
          col = 0;
          row = (p.px.y + 1 >= oh) ? 0 : p.px.y + 1;
        end else begin
          col = p.px.x + 1;
          row = p.px.y;
        end
      end
    endfunction

    function void check_result(scaled_pixel_t got);
      scaled_pixel_t exp_px;
      if (pending.size() == 0) begin
        $error("output pixel at (%0d, %0d) with no fetch outstanding", got.x, got.y);
        errors++;
        return;
      end
      exp_px = pending.pop_front();
      n_checked++;
      if (got.pixel !== exp_px.pixel) begin
        $error("pixel_out: expected %h, actual %h", exp_px.pixel, got.pixel);
        errors++;
      end
      if (got.x !== exp_px.x) begin
        $error("out_x: expected %0d, actual %0d", exp_px.x, got.x);
        errors++;
      end
      if (got.y !== exp_px.y) begin
        $error("out_y: expected %0d, actual %0d", exp_px.y, got.y);
        errors++;
      end
      if (got.eof !== exp_px.eof) begin
        $error("end_of_frame: expected %b, actual %b", exp_px.eof, got.eof);
        errors++;
      end
      if (got.width !== exp_px.width) begin
        $error("output_width: expected %0d, actual %0d", exp_px.width, got.width);
        errors++;
      end
      if (got.height !== exp_px.height) begin
        $error("output_height: expected %0d, actual %0d", exp_px.height, got.height);
        errors++;
      end
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  logic            req_type_i = nnis_pkg::ReqLoad;
  logic [PixW-1:0] pixel_in_i = '0;
  logic            out_valid_o;
  logic [PixW-1:0] pixel_out_o;
  logic [OutW-1:0] out_x_o;
  logic [OutW-1:0] out_y_o;
  logic            end_of_frame_o;
  logic [OutW-1:0] output_width_o;
  logic [OutW-1:0] output_height_o;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [3:0]      paddr = '0;
  logic [31:0]     pwdata = '0;
  logic [31:0]     prdata;
  logic            pready;

  scaler_scoreboard sb = new();
  int unsigned      activity_count = 0;
  int unsigned      activity_seen = 0;
  int unsigned      quiet_cycles = 0;
  bit               no_gaps = 1'b0;

  nearest_neighbor_image_scaler_top i_dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .req_type_i,
    .pixel_in_i,
    .out_valid_o,
    .pixel_out_o,
    .out_x_o,
    .out_y_o,
    .end_of_frame_o,
    .output_width_o,
    .output_height_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always #(ClkHalf) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    scaled_pixel_t got;
    if (rst_ni && out_valid_o === 1'b1) begin
      got.pixel  = pixel_out_o;
      got.x      = out_x_o;
      got.y      = out_y_o;
      got.eof    = end_of_frame_o;
      got.width  = output_width_o;
      got.height = output_height_o;
      sb.check_result(got);
      activity_count++;
    end
  end

  // Acceptances happen at the rising edge, so progress is judged at the falling one.
  always @(negedge clk_i) begin
    if (activity_count != activity_seen) begin
      activity_seen = activity_count;
      quiet_cycles  = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $error("no request or output pixel for %0d cycles", WatchdogLimit);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Entered and left at a falling edge.
  task automatic send_request(logic req, logic [PixW-1:0] pix);
    if (!no_gaps) begin
      while ($urandom_range(99) < IdlePercent) begin
        start <= 1'b0;
        @(negedge clk_i);
      end
    end
    start      <= 1'b1;
    req_type_i <= req;
    pixel_in_i <= pix;
    do @(posedge clk_i); while (busy);
    sb.note_request(req, pix);
    activity_count++;
    @(negedge clk_i);
  endtask

  task automatic write_register(int idx, int unsigned value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx * 4);
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(idx, value);
    activity_count++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // A fetch with no output pixel still keeps the block busy after the last
  // pixel has come, hence the extra wait.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned z);
    drain();
    write_register(nnis_pkg::RegSrcWidth, w);
    write_register(nnis_pkg::RegSrcHeight, h);
    write_register(nnis_pkg::RegZoom, z);
  endtask

  function automatic int unsigned pick_dim();
    case ($urandom_range(9))
      0:       return 256;
      1:       return $urandom_range(257, 511);
      2:       return 1;
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  function automatic int unsigned pick_zoom();
    case ($urandom_range(11))
      0:       return 1;
      1:       return 1023;
      2:       return 1000;
      3:       return 0;
      default: return $urandom_range(20, 400);
    endcase
  endfunction

  function automatic logic [PixW-1:0] pick_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return PixW'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  initial begin
    int unsigned w, h, z, n, total, phase_idx;
    total     = 0;
    phase_idx = 0;

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Default size after reset: load four pixels and read the first two back unscaled.
    send_request(nnis_pkg::ReqLoad, 24'hFFFFFF);
    send_request(nnis_pkg::ReqLoad, 24'h000000);
    send_request(nnis_pkg::ReqLoad, 24'hA5A5A5);
    send_request(nnis_pkg::ReqLoad, 24'h5A5A5A);
    send_request(nnis_pkg::ReqFetch, '0);
    send_request(nnis_pkg::ReqFetch, '0);

    // Empty source: the load is dropped and the fetch returns nothing.
    configure(0, 256, 100);
    send_request(nnis_pkg::ReqLoad, 24'h111111);
    send_request(nnis_pkg::ReqFetch, '0);

    // Zero zoom gives an empty output. The load pointer lies past the
    // one-pixel source and has to wrap to the first entry.
    configure(1, 1, 0);
    send_request(nnis_pkg::ReqFetch, '0);
    send_request(nnis_pkg::ReqLoad, 24'h123456);

    // A single pixel scales to a 4x4 frame with clamped coordinates.
    configure(1, 1, 100);
    repeat (16) send_request(nnis_pkg::ReqFetch, '0);

    while (total < RandomItems) begin
      case (phase_idx)
        0: begin w = 511; h = 2;   z = 1023; end
        1: begin w = 256; h = 1;   z = 1;    end
        2: begin w = 3;   h = 300; z = 1000; end
        3: begin w = 0;   h = 4;   z = 50;   end
        4: begin w = 5;   h = 5;   z = 100;  end
        default: begin
          w = pick_dim();
          h = pick_dim();
          z = pick_zoom();
        end
      endcase
      configure(w, h, z);
      no_gaps = (phase_idx == 4);
      n = (w == 0 || h == 0) ? 6 : (no_gaps ? 200 : $urandom_range(60, 140));
      repeat (n) begin
        if (sb.fetch_is_safe() && $urandom_range(99) < 60) begin
          send_request(nnis_pkg::ReqFetch, pick_pixel());
          total++;
        end else begin
          send_request(nnis_pkg::ReqLoad, pick_pixel());
          if (w != 0 && h != 0) total++;
        end
      end
      no_gaps = 1'b0;
      phase_idx++;
    end

    drain();
    $display("Sent %0d loads and %0d fetches over %0d register writes; %0d pixels checked.",
             sb.n_loads, sb.n_fetches, sb.n_settings, sb.n_checked);
    $display("Sizes ran from empty to 511 wide, zoom from 0 to 1023 percent.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
